[hw/rtl/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants for the stepper ramp profile
// Widths of the step counters and of the shared multiply/divide unit, command,
// phase, run mode and register index codes, and register reset values.
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int STEP_COUNT_WIDTH = 16;

    localparam int SPEED_W = 8;
    localparam int TICK_W  = 16;
    localparam int OFS_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int CMD_W   = 2;
    localparam int PHASE_W = 3;
    localparam int PM_W    = 10;
    localparam int MOVE_W  = 16;

    // shared unit sizing: quotient bits, divisor bits, remainder bits
    localparam int QW    = (STEP_COUNT_WIDTH > PM_W) ? STEP_COUNT_WIDTH : PM_W;
    localparam int DW    = (STEP_COUNT_WIDTH + 1 > PM_W) ? STEP_COUNT_WIDTH + 1 : PM_W;
    localparam int RW    = DW + QW;
    localparam int PW    = STEP_COUNT_WIDTH + PM_W;
    localparam int CNT_W = $clog2(QW);
    localparam int CMPW  = (STEP_COUNT_WIDTH > CFG_W) ? STEP_COUNT_WIDTH : CFG_W;

    typedef logic [STEP_COUNT_WIDTH-1:0] t_steps;
    typedef logic [STEP_COUNT_WIDTH:0]   t_steps_x;
    typedef logic [SPEED_W-1:0]          t_speed;
    typedef logic [TICK_W-1:0]           t_tick;
    typedef logic [OFS_W-1:0]            t_ofs;
    typedef logic [PM_W-1:0]             t_pm;
    typedef logic [RW-1:0]               t_rem;
    typedef logic [QW-1:0]               t_quo;
    typedef logic [CNT_W-1:0]            t_cnt;
    typedef logic [PW-1:0]               t_prod;
    typedef logic [CMPW-1:0]             t_cmp;

    localparam t_pm    PERMILLE_PM      = 10'd1000;
    localparam t_tick  TICK_LIMIT       = 16'd65000;
    localparam t_speed MAX_SPEED_RST    = 8'd255;
    localparam t_speed MIN_SPEED_RST    = 8'd50;
    localparam t_tick  RAMP_TICKS_RST   = 16'd30;
    localparam t_tick  CALIB_STEADY_RST = 16'd20000;
    localparam t_ofs   SENSOR_OFS_RST   = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 2'd0,
        CMD_PULSE       = 2'd1,
        CMD_START_MOVE  = 2'd2,
        CMD_START_CALIB = 2'd3
    } t_cmd;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_STEADY = 3'd2,
        PH_DECEL  = 3'd3,
        PH_CALIB  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        RM_CALIB = 2'd0,
        RM_LONG  = 2'd1,
        RM_SHORT = 2'd2,
        RM_NONE  = 2'd3
    } t_run_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_SPEED    = 3'd0,
        REG_MIN_SPEED    = 3'd1,
        REG_RAMP_TICKS   = 3'd2,
        REG_CALIB_STEADY = 3'd3,
        REG_STOP_SENSOR  = 3'd4,
        REG_SENSOR_OFS   = 3'd5
    } t_reg_idx;

endpackage

[hw/rtl/srp_in_if.sv]
// ----------------------------------------------------------------------------
// srp_in_if: command channel
// Valid/ready channel carrying one command with its step count and sensor level.
// ----------------------------------------------------------------------------
interface srp_in_if;
    logic                      valid;
    logic                      ready;
    logic [srp_pkg::CMD_W-1:0] cmd;
    logic [srp_pkg::MOVE_W-1:0] move_steps;
    logic                      position_sensor;

    modport source (output valid, output cmd, output move_steps, output position_sensor,
                    input ready);
    modport sink   (input valid, input cmd, input move_steps, input position_sensor,
                    output ready);
endinterface

[hw/rtl/srp_out_if.sv]
// ----------------------------------------------------------------------------
// srp_out_if: status channel
// Valid/ready channel carrying the speed code, run flag, phase and pulse level.
// ----------------------------------------------------------------------------
interface srp_out_if;
    logic                        valid;
    logic                        ready;
    logic [srp_pkg::SPEED_W-1:0] speed_code;
    logic                        motor_active;
    logic [srp_pkg::PHASE_W-1:0] phase;
    logic                        step_level;

    modport source (output valid, output speed_code, output motor_active, output phase,
                    output step_level, input ready);
    modport sink   (input valid, input speed_code, input motor_active, input phase,
                    input step_level, output ready);
endinterface

[hw/rtl/srp_cfg_if.sv]
// ----------------------------------------------------------------------------
// srp_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface srp_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [srp_pkg::IDX_W-1:0] wr_index;
    logic [srp_pkg::CFG_W-1:0] wr_data;

    modport source (output valid, output wr_index, output wr_data, input ready);
    modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

[hw/rtl/stepper_ramp_profile.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_profile: trapezoidal speed profile for a VCO-driven stepper
// Ramps the speed code on timer ticks, runs calibration and move phase machines
// on step feedback, computes the deceleration split with a shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one command per transaction (tick, step pulse, start move, start
//           calibration) with move_steps and position_sensor.
//   o_res : exactly one status transaction per command: speed code, run flag,
//           phase and step pin level after that command.
//   i_cfg : register writes, always ready; write only while the block is idle.
// Sequencing:
//   Most commands pass from acceptance through an execute state and a done
//   state, the status being registered out of the done state.
//   A pulse that completes calibration with a nonzero step total, and a start
//   move that takes the short profile, run one multiply and QW (16) restoring
//   divide steps in the shared unit before the done state.
//   i_in.ready is high only while the sequencer is idle.
// Reset: synchronous, active low; configuration and profile registers return
//   to their reset values, the output register is emptied.
// Stall: the status register holds until taken; the next command is accepted
//   meanwhile, and its status waits in the sequencer for the register to free.
// ----------------------------------------------------------------------------
module stepper_ramp_profile (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srp_in_if.sink    i_in,
    srp_out_if.source o_res,
    srp_cfg_if.sink   i_cfg
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    srp_pkg::t_speed r_max_speed, n_max_speed;
    srp_pkg::t_speed r_min_speed, n_min_speed;
    srp_pkg::t_tick  r_ramp_ticks, n_ramp_ticks;
    srp_pkg::t_tick  r_calib_steady, n_calib_steady;
    logic            r_stop_on_sensor, n_stop_on_sensor;
    srp_pkg::t_ofs   r_sensor_ofs, n_sensor_ofs;

    // profile state
    srp_pkg::t_speed    r_speed, n_speed;
    srp_pkg::t_tick     r_tick, n_tick;
    logic               r_ramping_up, n_ramping_up;
    logic               r_running, n_running;
    srp_pkg::t_run_mode r_run_mode, n_run_mode;
    srp_pkg::t_phase    r_phase, n_phase;
    srp_pkg::t_steps    r_steps_done, n_steps_done;
    srp_pkg::t_steps    r_target, n_target;
    srp_pkg::t_steps    r_accel, n_accel;
    srp_pkg::t_steps    r_decel, n_decel;
    srp_pkg::t_steps    r_steady, n_steady;
    srp_pkg::t_pm       r_decel_permille, n_decel_permille;
    srp_pkg::t_steps    r_decel_point, n_decel_point;
    srp_pkg::t_steps    r_short_point, n_short_point;
    logic               r_sensor_seen, n_sensor_seen;
    srp_pkg::t_ofs      r_offset_left, n_offset_left;
    logic               r_pulse_level, n_pulse_level;

    // latched command
    logic [srp_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [srp_pkg::MOVE_W-1:0] r_move_steps, n_move_steps;
    logic                       r_sensor, n_sensor;

    // shared multiply / divide unit
    srp_pkg::t_steps r_ma, n_ma;
    srp_pkg::t_pm    r_mb, n_mb;
    srp_pkg::t_rem   r_rem, n_rem;
    srp_pkg::t_rem   r_dvs, n_dvs;
    srp_pkg::t_quo   r_quo, n_quo;
    srp_pkg::t_cnt   r_cnt, n_cnt;
    logic            r_div_part, n_div_part;
    srp_pkg::t_prod  mul_p;

    // status register
    logic                        r_out_valid, n_out_valid;
    srp_pkg::t_speed             r_out_speed, n_out_speed;
    logic                        r_out_active, n_out_active;
    logic [srp_pkg::PHASE_W-1:0] r_out_phase, n_out_phase;
    logic                        r_out_level, n_out_level;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid        = r_out_valid;
    assign o_res.speed_code   = r_out_speed;
    assign o_res.motor_active = r_out_active;
    assign o_res.phase        = r_out_phase;
    assign o_res.step_level   = r_out_level;

    assign mul_p = srp_pkg::t_prod'(r_ma) * srp_pkg::t_prod'(r_mb);

    always_comb begin
        logic             stop_chk;
        srp_pkg::t_tick   tick_inc;
        srp_pkg::t_steps_x total;

        stop_chk = 1'b0;
        tick_inc = '0;
        total    = '0;

        n_state          = r_state;
        n_max_speed      = r_max_speed;
        n_min_speed      = r_min_speed;
        n_ramp_ticks     = r_ramp_ticks;
        n_calib_steady   = r_calib_steady;
        n_stop_on_sensor = r_stop_on_sensor;
        n_sensor_ofs     = r_sensor_ofs;
        n_speed          = r_speed;
        n_tick           = r_tick;
        n_ramping_up     = r_ramping_up;
        n_running        = r_running;
        n_run_mode       = r_run_mode;
        n_phase          = r_phase;
        n_steps_done     = r_steps_done;
        n_target         = r_target;
        n_accel          = r_accel;
        n_decel          = r_decel;
        n_steady         = r_steady;
        n_decel_permille = r_decel_permille;
        n_decel_point    = r_decel_point;
        n_short_point    = r_short_point;
        n_sensor_seen    = r_sensor_seen;
        n_offset_left    = r_offset_left;
        n_pulse_level    = r_pulse_level;
        n_cmd            = r_cmd;
        n_move_steps     = r_move_steps;
        n_sensor         = r_sensor;
        n_ma             = r_ma;
        n_mb             = r_mb;
        n_rem            = r_rem;
        n_dvs            = r_dvs;
        n_quo            = r_quo;
        n_cnt            = r_cnt;
        n_div_part       = r_div_part;
        n_out_valid      = r_out_valid & ~o_res.ready;
        n_out_speed      = r_out_speed;
        n_out_active     = r_out_active;
        n_out_phase      = r_out_phase;
        n_out_level      = r_out_level;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_cmd        = i_in.cmd;
                    n_move_steps = i_in.move_steps;
                    n_sensor     = i_in.position_sensor;
                    n_state      = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_cmd)
                    srp_pkg::CMD_TICK: begin
                        tick_inc = (r_tick < srp_pkg::TICK_LIMIT) ? r_tick + 1'b1 : r_tick;
                        n_tick   = tick_inc;
                        if (tick_inc >= r_ramp_ticks) begin
                            n_tick = '0;
                            if (r_ramping_up) begin
                                if (r_speed < r_max_speed) n_speed = r_speed + 1'b1;
                            end else begin
                                if (r_speed > r_min_speed) n_speed = r_speed - 1'b1;
                            end
                        end
                    end

                    srp_pkg::CMD_PULSE: begin
                        if (r_running && r_run_mode != srp_pkg::RM_NONE) begin
                            n_steps_done = (&r_steps_done) ? r_steps_done
                                                           : r_steps_done + 1'b1;
                            if (r_run_mode != srp_pkg::RM_CALIB)
                                n_pulse_level = ~r_pulse_level;
                            case (r_run_mode)
                                srp_pkg::RM_CALIB: begin
                                    if (r_phase == srp_pkg::PH_ACCEL) begin
                                        if (r_speed >= r_max_speed) begin
                                            n_accel = n_steps_done;
                                            n_phase = srp_pkg::PH_STEADY;
                                        end
                                    end else if (r_phase == srp_pkg::PH_STEADY) begin
                                        if (r_speed >= r_max_speed && r_ramping_up)
                                            n_steady = (&r_steady) ? r_steady : r_steady + 1'b1;
                                        else if (!r_ramping_up)
                                            n_phase = srp_pkg::PH_DECEL;
                                    end else if (r_phase == srp_pkg::PH_DECEL) begin
                                        if (!r_ramping_up)
                                            n_decel = (&r_decel) ? r_decel : r_decel + 1'b1;
                                        if (r_speed <= r_min_speed) begin
                                            n_phase   = srp_pkg::PH_CALIB;
                                            n_running = 1'b0;
                                            total = srp_pkg::t_steps_x'(r_accel)
                                                  + srp_pkg::t_steps_x'(n_decel);
                                            if (total == '0) begin
                                                n_decel_permille = '0;
                                            end else begin
                                                // permille = decel * 1000 / total
                                                n_ma       = n_decel;
                                                n_mb       = srp_pkg::PERMILLE_PM;
                                                n_dvs      = srp_pkg::t_rem'(total)
                                                             << (srp_pkg::QW - 1);
                                                n_div_part = 1'b0;
                                                n_state    = ST_MUL;
                                            end
                                        end
                                    end
                                end
                                srp_pkg::RM_LONG: begin
                                    if (r_phase == srp_pkg::PH_ACCEL) begin
                                        if (r_speed >= r_max_speed) begin
                                            n_decel_point = (r_target > r_decel)
                                                          ? r_target - r_decel : '0;
                                            n_phase = srp_pkg::PH_STEADY;
                                        end
                                    end else if (r_phase == srp_pkg::PH_STEADY) begin
                                        if (n_steps_done >= r_decel_point) begin
                                            n_ramping_up = 1'b0;
                                            n_phase      = srp_pkg::PH_DECEL;
                                        end
                                    end else if (r_phase == srp_pkg::PH_DECEL) begin
                                        stop_chk = 1'b1;
                                    end
                                end
                                srp_pkg::RM_SHORT: begin
                                    if (r_phase == srp_pkg::PH_ACCEL) begin
                                        if (n_steps_done >= r_short_point) begin
                                            n_ramping_up = 1'b0;
                                            n_phase      = srp_pkg::PH_STEADY;
                                        end
                                    end else if (r_phase == srp_pkg::PH_STEADY) begin
                                        stop_chk = 1'b1;
                                    end
                                end
                                default: ;
                            endcase

                            // final phase of a move: stop on count or sensor + offset
                            if (stop_chk) begin
                                if (r_stop_on_sensor) begin
                                    if (r_sensor || r_sensor_seen) begin
                                        n_sensor_seen = 1'b1;
                                        if (r_offset_left <= srp_pkg::t_ofs'(1)) begin
                                            n_running        = 1'b0;
                                            n_stop_on_sensor = 1'b0;
                                            n_offset_left    = r_sensor_ofs;
                                            n_sensor_seen    = 1'b0;
                                        end else begin
                                            n_offset_left = r_offset_left - 1'b1;
                                        end
                                    end
                                end else if (n_steps_done >= r_target) begin
                                    n_running = 1'b0;
                                end
                            end
                        end
                    end

                    srp_pkg::CMD_START_MOVE: begin
                        n_phase      = srp_pkg::PH_ACCEL;
                        n_steps_done = '0;
                        n_target     = srp_pkg::t_steps'(r_move_steps);
                        if (srp_pkg::t_steps_x'(n_target) <= srp_pkg::t_steps_x'(r_accel)
                                                            + srp_pkg::t_steps_x'(r_decel)) begin
                            // short profile: split point = target - target*permille/1000
                            n_run_mode = srp_pkg::RM_SHORT;
                            n_ma       = n_target;
                            n_mb       = r_decel_permille;
                            n_dvs      = srp_pkg::t_rem'(srp_pkg::PERMILLE_PM)
                                         << (srp_pkg::QW - 1);
                            n_div_part = 1'b1;
                            n_state    = ST_MUL;
                        end else begin
                            n_run_mode = srp_pkg::RM_LONG;
                        end
                        n_offset_left = r_sensor_ofs;
                        n_sensor_seen = 1'b0;
                        n_ramping_up  = 1'b1;
                        n_running     = 1'b1;
                    end

                    default: begin
                        n_run_mode    = srp_pkg::RM_CALIB;
                        n_phase       = srp_pkg::PH_ACCEL;
                        n_steps_done  = '0;
                        n_accel       = '0;
                        n_decel       = '0;
                        n_steady      = '0;
                        n_offset_left = r_sensor_ofs;
                        n_sensor_seen = 1'b0;
                        n_ramping_up  = 1'b1;
                        n_running     = 1'b1;
                    end
                endcase

                if (n_running && n_run_mode == srp_pkg::RM_CALIB
                        && srp_pkg::t_cmp'(n_steady) > srp_pkg::t_cmp'(r_calib_steady))
                    n_ramping_up = 1'b0;
            end

            ST_MUL: begin
                n_rem   = srp_pkg::t_rem'(mul_p);
                n_quo   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end

            ST_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (r_rem >= r_dvs) begin
                    n_rem = r_rem - r_dvs;
                    n_quo = {r_quo[srp_pkg::QW-2:0], 1'b1};
                end else begin
                    n_quo = {r_quo[srp_pkg::QW-2:0], 1'b0};
                end
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == srp_pkg::t_cnt'(srp_pkg::QW - 1))
                    n_state = ST_FIN;
            end

            ST_FIN: begin
                if (r_div_part)
                    n_short_point = r_target - r_quo[srp_pkg::STEP_COUNT_WIDTH-1:0];
                else
                    n_decel_permille = r_quo[srp_pkg::PM_W-1:0];
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_speed  = r_speed;
                    n_out_active = r_running;
                    n_out_phase  = r_phase;
                    n_out_level  = r_pulse_level;
                    n_state      = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        if (i_cfg.valid) begin
            case (i_cfg.wr_index)
                srp_pkg::REG_MAX_SPEED:    n_max_speed      = i_cfg.wr_data[srp_pkg::SPEED_W-1:0];
                srp_pkg::REG_MIN_SPEED:    n_min_speed      = i_cfg.wr_data[srp_pkg::SPEED_W-1:0];
                srp_pkg::REG_RAMP_TICKS:   n_ramp_ticks     = i_cfg.wr_data;
                srp_pkg::REG_CALIB_STEADY: n_calib_steady   = i_cfg.wr_data;
                srp_pkg::REG_STOP_SENSOR:  n_stop_on_sensor = i_cfg.wr_data[0];
                srp_pkg::REG_SENSOR_OFS:   n_sensor_ofs     = i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_out_valid      <= 1'b0;
            r_max_speed      <= srp_pkg::MAX_SPEED_RST;
            r_min_speed      <= srp_pkg::MIN_SPEED_RST;
            r_ramp_ticks     <= srp_pkg::RAMP_TICKS_RST;
            r_calib_steady   <= srp_pkg::CALIB_STEADY_RST;
            r_stop_on_sensor <= 1'b0;
            r_sensor_ofs     <= srp_pkg::SENSOR_OFS_RST;
            r_speed          <= srp_pkg::MIN_SPEED_RST;
            r_tick           <= '0;
            r_ramping_up     <= 1'b0;
            r_running        <= 1'b0;
            r_run_mode       <= srp_pkg::RM_CALIB;
            r_phase          <= srp_pkg::PH_IDLE;
            r_steps_done     <= '0;
            r_target         <= '0;
            r_accel          <= '0;
            r_decel          <= '0;
            r_steady         <= '0;
            r_decel_permille <= '0;
            r_decel_point    <= '0;
            r_short_point    <= '0;
            r_sensor_seen    <= 1'b0;
            r_offset_left    <= srp_pkg::SENSOR_OFS_RST;
            r_pulse_level    <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_out_valid      <= n_out_valid;
            r_max_speed      <= n_max_speed;
            r_min_speed      <= n_min_speed;
            r_ramp_ticks     <= n_ramp_ticks;
            r_calib_steady   <= n_calib_steady;
            r_stop_on_sensor <= n_stop_on_sensor;
            r_sensor_ofs     <= n_sensor_ofs;
            r_speed          <= n_speed;
            r_tick           <= n_tick;
            r_ramping_up     <= n_ramping_up;
            r_running        <= n_running;
            r_run_mode       <= n_run_mode;
            r_phase          <= n_phase;
            r_steps_done     <= n_steps_done;
            r_target         <= n_target;
            r_accel          <= n_accel;
            r_decel          <= n_decel;
            r_steady         <= n_steady;
            r_decel_permille <= n_decel_permille;
            r_decel_point    <= n_decel_point;
            r_short_point    <= n_short_point;
            r_sensor_seen    <= n_sensor_seen;
            r_offset_left    <= n_offset_left;
            r_pulse_level    <= n_pulse_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_move_steps <= n_move_steps;
        r_sensor     <= n_sensor;
        r_ma         <= n_ma;
        r_mb         <= n_mb;
        r_rem        <= n_rem;
        r_dvs        <= n_dvs;
        r_quo        <= n_quo;
        r_cnt        <= n_cnt;
        r_div_part   <= n_div_part;
        r_out_speed  <= n_out_speed;
        r_out_active <= n_out_active;
        r_out_phase  <= n_out_phase;
        r_out_level  <= n_out_level;
    end

    // the split ratio can never exceed one
    a_permille_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decel_permille <= srp_pkg::PERMILLE_PM)
        else $error("decel permille above 1000");

    // status only becomes valid out of the final sequencer state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("status loaded outside done state");

    // the divide runs exactly QW steps before finishing
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != srp_pkg::t_cnt'(srp_pkg::QW - 1)) |=> r_state == ST_DIV)
        else $error("divide ended early");

    // a divide is only started by a calibration end or a short move start
    a_mul_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_MUL) |->
            ($past(r_cmd) == srp_pkg::CMD_PULSE || $past(r_cmd) == srp_pkg::CMD_START_MOVE))
        else $error("divide started by wrong command");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stepper ramp profile, self-checking
// Drives ticks, step pulses and start commands through the command channel,
// with register writes between phases. A transaction-level profile predictor
// works out the status after every accepted command, and each status
// transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 142;

    typedef struct packed {
        t_speed speed;
        logic   active;
        t_phase ph;
        logic   pin;
    } t_status;

    typedef struct packed {
        logic        is_cfg;
        t_cmd        cmd;
        t_steps      steps;
        logic        sens;
        t_reg_idx    reg_idx;
        logic [15:0] data;
        logic        typed;
        t_status     want;
    } t_row;

    localparam t_status NO_STATUS   = '0;
    localparam t_status AT_RESET    = '{MIN_SPEED_RST, 1'b0, PH_IDLE, 1'b0};
    localparam t_status CALIB_START = '{MIN_SPEED_RST, 1'b1, PH_ACCEL, 1'b0};
    localparam int PLAN_ROWS = 28;

    // short calibration, two-code ramp, long move, short moves by count and sensor
    localparam t_row PLAN [0:PLAN_ROWS-1] = '{
        '{1'b0, CMD_PULSE,       16'hFFFF, 1'b1, REG_MAX_SPEED,    16'd0,  1'b1, AT_RESET},
        '{1'b0, CMD_TICK,        16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b1, AT_RESET},
        '{1'b1, CMD_TICK,        16'd0,    1'b0, REG_MAX_SPEED,    16'd52, 1'b0, NO_STATUS},
        '{1'b1, CMD_TICK,        16'd0,    1'b0, REG_MIN_SPEED,    16'd50, 1'b0, NO_STATUS},
        '{1'b1, CMD_TICK,        16'd0,    1'b0, REG_RAMP_TICKS,   16'd0,  1'b0, NO_STATUS},
        '{1'b1, CMD_TICK,        16'd0,    1'b0, REG_CALIB_STEADY, 16'd1,  1'b0, NO_STATUS},
        '{1'b0, CMD_START_CALIB, 16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b1, CALIB_START},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_TICK,        16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_TICK,        16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_TICK,        16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_TICK,        16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_TICK,        16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_START_MOVE,  16'hFFFF, 1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_START_MOVE,  16'd2,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b1, CMD_TICK,        16'd0,    1'b0, REG_STOP_SENSOR,  16'd1,  1'b0, NO_STATUS},
        '{1'b1, CMD_TICK,        16'd0,    1'b0, REG_SENSOR_OFS,   16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_START_MOVE,  16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b0, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS},
        '{1'b0, CMD_PULSE,       16'd0,    1'b1, REG_MAX_SPEED,    16'd0,  1'b0, NO_STATUS}
    };

    logic i_clk;
    logic i_rst_n;

    srp_in_if  cmd_ch ();
    srp_out_if status_ch ();
    srp_cfg_if reg_ch ();

    stepper_ramp_profile i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_res   (status_ch),
        .i_cfg   (reg_ch)
    );

    // register copies
    t_speed cfg_max, cfg_min;
    t_tick  cfg_ramp, cfg_steady;
    logic   cfg_stop_sens;
    t_ofs   cfg_ofs;

    // profile state
    t_speed    cur_speed;
    t_tick     tick_cnt;
    logic      ramp_up, motor_on, sens_seen, pin;
    t_run_mode mode;
    t_phase    ph;
    t_steps    done_cnt, target, accel_cnt, decel_cnt, steady_cnt, decel_at, short_at;
    t_pm       pm;
    t_ofs      ofs_left;

    t_status pending_status [$];
    t_status head;
    int      mismatches;
    int      busy_items;
    int      quota;
    int      tx_idle, rx_idle;
    int      hold_cnt;
    logic    hold_go;

    always #4 i_clk = ~i_clk;

    function automatic t_steps bump(input t_steps x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    // final-phase stop: step count, or sensor plus offset (one-shot)
    task automatic halt_check(input logic sens);
        begin
            if (cfg_stop_sens) begin
                if (sens || sens_seen) begin
                    sens_seen = 1'b1;
                    if (ofs_left <= 1) begin
                        motor_on      = 1'b0;
                        cfg_stop_sens = 1'b0;
                        ofs_left      = cfg_ofs;
                        sens_seen     = 1'b0;
                    end else begin
                        ofs_left = ofs_left - 1'b1;
                    end
                end
            end else if (done_cnt >= target) begin
                motor_on = 1'b0;
            end
        end
    endtask

    task automatic advance_profile(input t_cmd c, input t_steps n, input logic sens);
        longint unsigned span;
        longint unsigned part;
        begin
            span = longint'(accel_cnt) + longint'(decel_cnt);
            case (c)
                CMD_TICK: begin
                    if (tick_cnt < TICK_LIMIT) tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= cfg_ramp) begin
                        tick_cnt = '0;
                        if (ramp_up) begin
                            if (cur_speed < cfg_max) cur_speed = cur_speed + 1'b1;
                        end else if (cur_speed > cfg_min) begin
                            cur_speed = cur_speed - 1'b1;
                        end
                    end
                end
                CMD_PULSE: if (motor_on) begin
                    case (mode)
                        RM_CALIB: begin
                            done_cnt = bump(done_cnt);
                            case (ph)
                                PH_ACCEL: if (cur_speed >= cfg_max) begin
                                    accel_cnt = done_cnt;
                                    ph        = PH_STEADY;
                                end
                                PH_STEADY: begin
                                    if (cur_speed >= cfg_max && ramp_up)
                                        steady_cnt = bump(steady_cnt);
                                    else if (!ramp_up)
                                        ph = PH_DECEL;
                                end
                                PH_DECEL: begin
                                    if (!ramp_up) decel_cnt = bump(decel_cnt);
                                    if (cur_speed <= cfg_min) begin
                                        span     = longint'(accel_cnt) + longint'(decel_cnt);
                                        ph       = PH_CALIB;
                                        motor_on = 1'b0;
                                        pm = (span == 0) ? '0 :
                                             t_pm'((longint'(decel_cnt) * 1000) / span);
                                    end
                                end
                                default: ;
                            endcase
                        end
                        RM_LONG: begin
                            done_cnt = bump(done_cnt);
                            pin      = ~pin;
                            case (ph)
                                PH_ACCEL: if (cur_speed >= cfg_max) begin
                                    decel_at = (target > decel_cnt) ? target - decel_cnt : '0;
                                    ph       = PH_STEADY;
                                end
                                PH_STEADY: if (done_cnt >= decel_at) begin
                                    ramp_up = 1'b0;
                                    ph      = PH_DECEL;
                                end
                                PH_DECEL: halt_check(sens);
                                default: ;
                            endcase
                        end
                        RM_SHORT: begin
                            done_cnt = bump(done_cnt);
                            pin      = ~pin;
                            case (ph)
                                PH_ACCEL: if (done_cnt >= short_at) begin
                                    ramp_up = 1'b0;
                                    ph      = PH_STEADY;
                                end
                                PH_STEADY: halt_check(sens);
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                CMD_START_MOVE: begin
                    ph       = PH_ACCEL;
                    done_cnt = '0;
                    target   = n;
                    if (longint'(target) <= span) begin
                        part     = (longint'(target) * longint'(pm)) / 1000;
                        mode     = RM_SHORT;
                        short_at = target - t_steps'(part);
                    end else begin
                        mode = RM_LONG;
                    end
                    ofs_left  = cfg_ofs;
                    sens_seen = 1'b0;
                    ramp_up   = 1'b1;
                    motor_on  = 1'b1;
                end
                default: begin
                    mode       = RM_CALIB;
                    ph         = PH_ACCEL;
                    done_cnt   = '0;
                    accel_cnt  = '0;
                    decel_cnt  = '0;
                    steady_cnt = '0;
                    ofs_left   = cfg_ofs;
                    sens_seen  = 1'b0;
                    ramp_up    = 1'b1;
                    motor_on   = 1'b1;
                end
            endcase
            if (motor_on && mode == RM_CALIB && steady_cnt > cfg_steady) ramp_up = 1'b0;
        end
    endtask

    task automatic issue_cmd(input t_cmd c, input t_steps n, input logic sens,
                             input logic typed, input t_status fixed);
        int   gap;
        logic counted;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < tx_idle) gap++;
            @(negedge i_clk);
            if (gap != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            cmd_ch.valid           <= 1'b1;
            cmd_ch.cmd             <= c;
            cmd_ch.move_steps      <= n;
            cmd_ch.position_sensor <= sens;
            do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
            counted = !(c == CMD_PULSE && !motor_on);
            if (counted) busy_items++;
            advance_profile(c, n, sens);
            pending_status.push_back(typed ? fixed :
                                     t_status'({cur_speed, motor_on, ph, pin}));
        end
    endtask

    // drop valid and wait for every outstanding status
    task automatic quiesce;
        begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
            while (pending_status.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx r, input logic [15:0] d);
        begin
            @(negedge i_clk);
            reg_ch.valid    <= 1'b1;
            reg_ch.wr_index <= r;
            reg_ch.wr_data  <= d;
            do @(posedge i_clk); while (reg_ch.ready !== 1'b1);
            case (r)
                REG_MAX_SPEED:    cfg_max       = d[7:0];
                REG_MIN_SPEED:    cfg_min       = d[7:0];
                REG_RAMP_TICKS:   cfg_ramp      = d;
                REG_CALIB_STEADY: cfg_steady    = d;
                REG_STOP_SENSOR:  cfg_stop_sens = d[0];
                REG_SENSOR_OFS:   cfg_ofs       = d;
                default: ;
            endcase
            @(negedge i_clk);
            reg_ch.valid <= 1'b0;
        end
    endtask

    // ticks and pulses until the run ends, with the odd restart thrown in
    task automatic run_motion(input int cap);
        int k;
        int r;
        begin
            for (k = 0; k < cap && motor_on && busy_items < quota; k++) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    issue_cmd(CMD_TICK, t_steps'($urandom), $urandom_range(0, 1),
                              1'b0, NO_STATUS);
                else if (r < 96)
                    issue_cmd(CMD_PULSE, t_steps'($urandom), $urandom_range(0, 99) < 15,
                              1'b0, NO_STATUS);
                else
                    issue_cmd(t_cmd'($urandom_range(0, 3)), t_steps'($urandom),
                              $urandom_range(0, 1), 1'b0, NO_STATUS);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] exp);
        begin
            if (got !== exp) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp, got);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected status transaction, actual %0d %0d %0d %0d",
                         $time, status_ch.speed_code, status_ch.motor_active,
                         status_ch.phase, status_ch.step_level);
                mismatches++;
            end else begin
                head = pending_status.pop_front();
                check_field("speed_code", status_ch.speed_code, head.speed);
                check_field("motor_active", status_ch.motor_active, head.active);
                check_field("phase", status_ch.phase, head.ph);
                check_field("step_level", status_ch.step_level, head.pin);
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off once asked for
    always @(negedge i_clk) begin
        if (hold_go && hold_cnt < HOLD_CYCLES) begin
            hold_cnt = hold_cnt + 1;
            status_ch.ready <= 1'b0;
        end else begin
            status_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin
        int          k;
        int          p;
        t_steps      n;
        longint      span;
        logic [15:0] mx, mn, rt, st, so, of;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = '0;
        cmd_ch.move_steps = '0;
        cmd_ch.position_sensor = 1'b0;
        reg_ch.valid = 1'b0;
        reg_ch.wr_index = '0;
        reg_ch.wr_data = '0;
        status_ch.ready = 1'b0;
        mismatches = 0;
        busy_items = 0;
        quota = 0;
        hold_cnt = 0;
        hold_go = 1'b0;
        tx_idle = 22;
        rx_idle = 84;

        cfg_max = MAX_SPEED_RST;
        cfg_min = MIN_SPEED_RST;
        cfg_ramp = RAMP_TICKS_RST;
        cfg_steady = CALIB_STEADY_RST;
        cfg_stop_sens = 1'b0;
        cfg_ofs = SENSOR_OFS_RST;
        cur_speed = MIN_SPEED_RST;
        tick_cnt = '0;
        ramp_up = 1'b0;
        motor_on = 1'b0;
        sens_seen = 1'b0;
        pin = 1'b0;
        mode = RM_CALIB;
        ph = PH_IDLE;
        done_cnt = '0;
        target = '0;
        accel_cnt = '0;
        decel_cnt = '0;
        steady_cnt = '0;
        decel_at = '0;
        short_at = '0;
        pm = '0;
        ofs_left = SENSOR_OFS_RST;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        quota = PLAN_ROWS;
        for (k = 0; k < PLAN_ROWS; k++) begin
            if (PLAN[k].is_cfg) begin
                quiesce();
                write_reg(PLAN[k].reg_idx, PLAN[k].data);
            end else begin
                issue_cmd(PLAN[k].cmd, PLAN[k].steps, PLAN[k].sens, PLAN[k].typed,
                          PLAN[k].want);
            end
        end

        for (p = 0; p < 6; p++) begin
            if (p == 2) begin
                tx_idle = 84;
                rx_idle = 22;
            end else if (p == 4) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case (p)
                0: begin
                    mn = 250; mx = 255; rt = $urandom_range(0, 3); st = 0; of = 0;
                end
                1: begin
                    mn = 0; mx = 4; rt = 0; st = $urandom_range(0, 6); of = 1;
                end
                // ceiling below floor, ramps step only once the tick count saturates
                2: begin
                    mn = 20; mx = 10; rt = TICK_LIMIT; st = $urandom_range(0, 6); of = 16'hFFFF;
                end
                // steady count can never pass the threshold: calibration stays steady
                3: begin
                    mn = $urandom_range(0, 250); mx = mn + $urandom_range(1, 5);
                    rt = $urandom_range(0, 3); st = 16'hFFFF; of = $urandom_range(1, 6);
                end
                default: begin
                    mn = $urandom_range(0, 250); mx = mn + $urandom_range(0, 5);
                    rt = $urandom_range(0, 3); st = $urandom_range(0, 6);
                    of = $urandom_range(1, 6);
                end
            endcase
            so = $urandom_range(0, 1);
            quiesce();
            write_reg(REG_MAX_SPEED, mx);
            write_reg(REG_MIN_SPEED, mn);
            write_reg(REG_RAMP_TICKS, rt);
            write_reg(REG_CALIB_STEADY, st);
            write_reg(REG_STOP_SENSOR, so);
            write_reg(REG_SENSOR_OFS, of);
            if (p == 4) hold_go = 1'b1;
            quota = busy_items + PHASE_ITEMS;

            while (busy_items < quota) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        issue_cmd(CMD_START_CALIB, t_steps'($urandom), $urandom_range(0, 1),
                                  1'b0, NO_STATUS);
                        run_motion(120);
                    end
                    3, 4, 5, 6, 7: begin
                        // re-arm or clear the one-shot sensor stop on half the moves
                        if ($urandom_range(0, 1)) begin
                            quiesce();
                            write_reg(REG_STOP_SENSOR, 16'($urandom_range(0, 2) != 0));
                        end
                        span = longint'(accel_cnt) + longint'(decel_cnt);
                        case ($urandom_range(0, 5))
                            0: n = t_steps'($urandom_range(0, (span > 65535) ? 65535 : span));
                            1, 2: begin
                                span = span + $urandom_range(1, 24);
                                n = (span > 65535) ? 16'hFFFF : t_steps'(span);
                            end
                            3: n = t_steps'($urandom_range(0, 40));
                            4: n = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                            default: n = t_steps'($urandom);
                        endcase
                        issue_cmd(CMD_START_MOVE, n, $urandom_range(0, 1), 1'b0, NO_STATUS);
                        run_motion(160);
                    end
                    default: begin
                        repeat ($urandom_range(1, 6))
                            issue_cmd(t_cmd'($urandom_range(0, 3)), t_steps'($urandom),
                                      $urandom_range(0, 1), 1'b0, NO_STATUS);
                    end
                endcase
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[stepper_ramp_profile.f]
hw/rtl/srp_pkg.sv
hw/rtl/srp_in_if.sv
hw/rtl/srp_out_if.sv
hw/rtl/srp_cfg_if.sv
hw/rtl/stepper_ramp_profile.sv
sim/testbench.sv
